FILE: src/sra_pkg.sv
package sra_pkg;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_LEGACY  = 2'd1,
    MODE_PERSIST = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_RESERVE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CHECK   = 2'd2,
    KIND_PR_SET  = 2'd3
  } kind_t;

  localparam logic [4:0] SA_MASK      = 5'h1F;
  localparam logic [4:0] SA_READCAP16 = 5'h10;

  localparam logic [3:0] PR_NONE     = 4'd0;
  localparam logic [3:0] PR_WE       = 4'd1;
  localparam logic [3:0] PR_EA       = 4'd3;
  localparam logic [3:0] PR_WE_RO    = 4'd5;
  localparam logic [3:0] PR_EA_RO    = 4'd6;
  localparam logic [3:0] PR_WE_AR    = 4'd7;
  localparam logic [3:0] PR_EA_AR    = 4'd8;

  localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
  localparam logic [7:0] OP_REQUEST_SENSE   = 8'h03;
  localparam logic [7:0] OP_READ6           = 8'h08;
  localparam logic [7:0] OP_WRITE6          = 8'h0A;
  localparam logic [7:0] OP_INQUIRY         = 8'h12;
  localparam logic [7:0] OP_RELEASE         = 8'h17;
  localparam logic [7:0] OP_MODE_SENSE      = 8'h1A;
  localparam logic [7:0] OP_START_STOP      = 8'h1B;
  localparam logic [7:0] OP_READ_CAPACITY   = 8'h25;
  localparam logic [7:0] OP_READ10          = 8'h28;
  localparam logic [7:0] OP_WRITE10         = 8'h2A;
  localparam logic [7:0] OP_WRITE_VERIFY    = 8'h2E;
  localparam logic [7:0] OP_VERIFY10        = 8'h2F;
  localparam logic [7:0] OP_SYNC_CACHE      = 8'h35;
  localparam logic [7:0] OP_PR_IN           = 8'h5E;
  localparam logic [7:0] OP_PR_OUT          = 8'h5F;
  localparam logic [7:0] OP_READ16          = 8'h88;
  localparam logic [7:0] OP_WRITE16         = 8'h8A;
  localparam logic [7:0] OP_VERIFY16        = 8'h8F;
  localparam logic [7:0] OP_WRITE_SAME16    = 8'h93;
  localparam logic [7:0] OP_SERVICE_IN      = 8'h9E;
  localparam logic [7:0] OP_REPORT_LUNS     = 8'hA0;
  localparam logic [7:0] OP_READ12          = 8'hA8;
  localparam logic [7:0] OP_WRITE12         = 8'hAA;

  function automatic logic is_readcap16(input logic [7:0] second);
    is_readcap16 = ((second[4:0] & SA_MASK) == SA_READCAP16);
  endfunction

  function automatic logic check_legacy(input logic [7:0] op, input logic [7:0] second);
    logic res;
    res = 1'b1;
    unique case (op)
      OP_INQUIRY, OP_RELEASE, OP_REPORT_LUNS, OP_REQUEST_SENSE, OP_READ_CAPACITY: begin
        res = 1'b0;
      end
      OP_SERVICE_IN: begin
        res = !is_readcap16(second);
      end
      default: begin
        res = 1'b1;
      end
    endcase
    check_legacy = res;
  endfunction

  function automatic logic check_persistent(input logic [7:0] op, input logic [7:0] second,
                                            input logic reg_ok, input logic [3:0] t);
    logic we;
    logic ea;
    logic we_ro;
    logic ea_ro;
    logic res;
    we    = (t == PR_WE);
    ea    = (t == PR_EA);
    we_ro = (t == PR_WE_RO) || (t == PR_WE_AR);
    ea_ro = (t == PR_EA_RO) || (t == PR_EA_AR);
    res   = 1'b1;
    unique case (op)
      OP_INQUIRY, OP_TEST_UNIT_READY, OP_PR_IN, OP_PR_OUT,
      OP_REPORT_LUNS, OP_REQUEST_SENSE, OP_READ_CAPACITY, OP_START_STOP: begin
        res = 1'b0;
      end
      OP_MODE_SENSE, OP_WRITE6, OP_WRITE10, OP_WRITE12, OP_WRITE16,
      OP_WRITE_SAME16, OP_WRITE_VERIFY, OP_SYNC_CACHE: begin
        res = we || ea || ((we_ro || ea_ro) && !reg_ok);
      end
      OP_READ6, OP_READ10, OP_READ12, OP_READ16, OP_VERIFY10, OP_VERIFY16: begin
        res = ea || (ea_ro && !reg_ok);
      end
      OP_SERVICE_IN: begin
        res = !is_readcap16(second);
      end
      default: begin
        res = 1'b1;
      end
    endcase
    check_persistent = res;
  endfunction

endpackage

FILE: src/scsi_reservation_access_check.sv
// Channel  Handshake                 Payload
// input    in_valid / in_stall       kind, session_id, force_req, opcode, second_byte,
//                                    registered, pr_type_code
// output   out_valid / out_stall     status
//
// Each word passes an input register and then a result register before its status is offered,
// and one word can be accepted every cycle while the output is not stalled.
// The reservation state is updated as the result register is loaded, so the next
// word is decided against the updated state. Synchronous reset clears the state
// to no reservation. A stalled result holds the result register and, once the
// input register is also full, the input side stalls.
module scsi_reservation_access_check
  import sra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [63:0] session_id,
  input  logic        force_req,
  input  logic [7:0]  opcode,
  input  logic [7:0]  second_byte,
  input  logic        registered,
  input  logic [3:0]  pr_type_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status
);

  logic        s1_valid;
  kind_t       s1_kind;
  logic [63:0] s1_session;
  logic        s1_force;
  logic [7:0]  s1_opcode;
  logic [7:0]  s1_second;
  logic        s1_registered;
  logic [3:0]  s1_code;

  mode_t       reserve_mode;
  logic [63:0] holder_session;
  logic [3:0]  persistent_kind;

  mode_t       reserve_mode_next;
  logic [63:0] holder_session_next;
  logic [3:0]  persistent_kind_next;
  logic        status_next;

  logic        advance;
  logic        take;
  logic        reserved;
  logic        is_holder;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign take     = in_valid && !in_stall;

  assign reserved  = (reserve_mode != MODE_NONE);
  assign is_holder = (holder_session == s1_session);

  always_comb begin
    reserve_mode_next    = reserve_mode;
    holder_session_next  = holder_session;
    persistent_kind_next = persistent_kind;
    status_next          = 1'b0;
    unique case (s1_kind)
      KIND_RESERVE: begin
        if (reserved && !is_holder) begin
          status_next = 1'b1;
        end else begin
          reserve_mode_next   = MODE_LEGACY;
          holder_session_next = s1_session;
        end
      end
      KIND_RELEASE: begin
        if (reserve_mode == MODE_LEGACY && (s1_force || is_holder)) begin
          reserve_mode_next   = MODE_NONE;
          holder_session_next = '0;
        end else begin
          status_next = 1'b1;
        end
      end
      KIND_CHECK: begin
        if (!reserved || is_holder) begin
          status_next = 1'b0;
        end else if (reserve_mode == MODE_LEGACY) begin
          status_next = check_legacy(s1_opcode, s1_second);
        end else begin
          status_next = check_persistent(s1_opcode, s1_second, s1_registered,
                                         persistent_kind);
        end
      end
      KIND_PR_SET: begin
        if (s1_code == PR_NONE) begin
          reserve_mode_next    = MODE_NONE;
          holder_session_next  = '0;
          persistent_kind_next = PR_NONE;
        end else begin
          reserve_mode_next    = MODE_PERSIST;
          holder_session_next  = s1_session;
          persistent_kind_next = s1_code;
        end
      end
      default: begin
        status_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      reserve_mode    <= MODE_NONE;
      holder_session  <= '0;
      persistent_kind <= PR_NONE;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid       <= 1'b1;
        reserve_mode    <= reserve_mode_next;
        holder_session  <= holder_session_next;
        persistent_kind <= persistent_kind_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind       <= kind_t'(kind);
      s1_session    <= session_id;
      s1_force      <= force_req;
      s1_opcode     <= opcode;
      s1_second     <= second_byte;
      s1_registered <= registered;
      s1_code       <= pr_type_code;
    end
    if (advance) begin
      status <= status_next;
    end
  end

endmodule

FILE: test/tb_top.sv
module tb_top
  import sra_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] session_id;
    logic        force_req;
    logic [7:0]  opcode;
    logic [7:0]  second_byte;
    logic        reg_flag;
    logic [3:0]  pr_type_code;
  } access_word_t;

  typedef struct packed {
    access_word_t word;
    bit           typed;
    bit           typed_status;
  } stim_row_t;

  localparam int RANDOM_WORDS = 1350;
  localparam int HOLD_CYCLES  = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = KIND_RESERVE;
  logic [63:0] session_id = '0;
  logic        force_req = 1'b0;
  logic [7:0]  opcode = '0;
  logic [7:0]  second_byte = '0;
  logic        registered = 1'b0;
  logic [3:0]  pr_type_code = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        status;

  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  bit          out_status_s = 1'b0;

  mode_t       lun_mode = MODE_NONE;
  logic [63:0] lun_holder = '0;
  logic [3:0]  lun_pr_type = PR_NONE;

  bit          pending_status[$];
  stim_row_t   stim_rows[$];
  logic [63:0] sid_pool[4];
  int          mismatches = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;

  scsi_reservation_access_check dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .session_id(session_id),
    .force_req(force_req),
    .opcode(opcode),
    .second_byte(second_byte),
    .registered(registered),
    .pr_type_code(pr_type_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    in_fire      = (in_valid === 1'b1) && (in_stall === 1'b0) && (rst === 1'b0);
    out_fire     = (out_valid === 1'b1) && (out_stall === 1'b0) && (rst === 1'b0);
    out_status_s = status;
  end

  function automatic bit command_conflict(input access_word_t w);
    bit rc16;
    bit blk_wr;
    bit blk_rd;
    bit ro_types;
    rc16     = (w.second_byte[4:0] == SA_READCAP16);
    ro_types = (lun_pr_type == PR_WE_RO) || (lun_pr_type == PR_WE_AR) ||
               (lun_pr_type == PR_EA_RO) || (lun_pr_type == PR_EA_AR);
    blk_wr   = (lun_pr_type == PR_WE) || (lun_pr_type == PR_EA) || (ro_types && !w.reg_flag);
    blk_rd   = (lun_pr_type == PR_EA) ||
               (((lun_pr_type == PR_EA_RO) || (lun_pr_type == PR_EA_AR)) && !w.reg_flag);
    if (lun_mode == MODE_LEGACY) begin
      case (w.opcode)
        OP_INQUIRY, OP_RELEASE, OP_REPORT_LUNS, OP_REQUEST_SENSE, OP_READ_CAPACITY: return 1'b0;
        OP_SERVICE_IN: return !rc16;
        default: return 1'b1;
      endcase
    end
    case (w.opcode)
      OP_INQUIRY, OP_TEST_UNIT_READY, OP_PR_IN, OP_PR_OUT,
      OP_REPORT_LUNS, OP_REQUEST_SENSE, OP_READ_CAPACITY, OP_START_STOP: return 1'b0;
      OP_MODE_SENSE, OP_WRITE6, OP_WRITE10, OP_WRITE12, OP_WRITE16,
      OP_WRITE_SAME16, OP_WRITE_VERIFY, OP_SYNC_CACHE: return blk_wr;
      OP_READ6, OP_READ10, OP_READ12, OP_READ16, OP_VERIFY10, OP_VERIFY16: return blk_rd;
      OP_SERVICE_IN: return !rc16;
      default: return 1'b1;
    endcase
  endfunction

  function automatic bit predict_status(input access_word_t w);
    bit st;
    st = 1'b0;
    case (w.kind)
      KIND_RESERVE: begin
        if (lun_mode != MODE_NONE && lun_holder != w.session_id) begin
          st = 1'b1;
        end else begin
          lun_mode   = MODE_LEGACY;
          lun_holder = w.session_id;
        end
      end
      KIND_RELEASE: begin
        if (lun_mode == MODE_LEGACY && (w.force_req || lun_holder == w.session_id)) begin
          lun_mode   = MODE_NONE;
          lun_holder = '0;
        end else begin
          st = 1'b1;
        end
      end
      KIND_CHECK: begin
        if (lun_mode != MODE_NONE && lun_holder != w.session_id) begin
          st = command_conflict(w);
        end
      end
      default: begin
        if (w.pr_type_code == PR_NONE) begin
          lun_mode    = MODE_NONE;
          lun_holder  = '0;
          lun_pr_type = PR_NONE;
        end else begin
          lun_mode    = MODE_PERSIST;
          lun_holder  = w.session_id;
          lun_pr_type = w.pr_type_code;
        end
      end
    endcase
    return st;
  endfunction

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(27))
      0: return OP_TEST_UNIT_READY;
      1: return OP_REQUEST_SENSE;
      2: return OP_READ6;
      3: return OP_WRITE6;
      4: return OP_INQUIRY;
      5: return OP_RELEASE;
      6: return OP_MODE_SENSE;
      7: return OP_START_STOP;
      8: return OP_READ_CAPACITY;
      9: return OP_READ10;
      10: return OP_WRITE10;
      11: return OP_WRITE_VERIFY;
      12: return OP_VERIFY10;
      13: return OP_SYNC_CACHE;
      14: return OP_PR_IN;
      15: return OP_PR_OUT;
      16: return OP_READ16;
      17: return OP_WRITE16;
      18: return OP_VERIFY16;
      19: return OP_WRITE_SAME16;
      20, 21: return OP_SERVICE_IN;
      22: return OP_REPORT_LUNS;
      23: return OP_READ12;
      24: return OP_WRITE12;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic access_word_t random_word();
    access_word_t w;
    int roll;
    roll = $urandom_range(99);
    if (roll < 50) begin
      w.kind = KIND_CHECK;
    end else if (roll < 65) begin
      w.kind = KIND_RESERVE;
    end else if (roll < 80) begin
      w.kind = KIND_RELEASE;
    end else begin
      w.kind = KIND_PR_SET;
    end
    if ($urandom_range(9) == 0) begin
      w.session_id = {$urandom, $urandom};
    end else begin
      w.session_id = sid_pool[$urandom_range(3)];
    end
    w.force_req = 1'($urandom_range(1));
    w.opcode    = pick_opcode();
    if ($urandom_range(1)) begin
      w.second_byte = {3'($urandom), SA_READCAP16};
    end else begin
      w.second_byte = 8'($urandom);
    end
    w.reg_flag = 1'($urandom_range(1));
    if ($urandom_range(4) == 0) begin
      w.pr_type_code = 4'($urandom);
    end else begin
      w.pr_type_code = 4'($urandom_range(8));
    end
    return w;
  endfunction

  task automatic stage_row(input kind_t k, input logic [63:0] sid, input logic frc,
                           input logic [7:0] op, input logic [7:0] sb, input logic rg,
                           input logic [3:0] code, input bit typed, input bit st);
    stim_row_t r;
    r.word = '{k, sid, frc, op, sb, rg, code};
    r.typed = typed;
    r.typed_status = st;
    stim_rows.push_back(r);
  endtask

  task automatic offer_word(input access_word_t w, input bit typed, input bit typed_status);
    bit predicted;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= w.kind;
    session_id   <= w.session_id;
    force_req    <= w.force_req;
    opcode       <= w.opcode;
    second_byte  <= w.second_byte;
    registered   <= w.reg_flag;
    pr_type_code <= w.pr_type_code;
    @(posedge clk);
    while (!in_fire) begin
      @(posedge clk);
    end
    predicted = predict_status(w);
    pending_status.push_back(typed ? typed_status : predicted);
  endtask

  always @(posedge clk) begin
    if (out_fire) begin
      if (pending_status.size() == 0) begin
        $display("%0t unexpected word: expected none, actual status %0b", $time, out_status_s);
        mismatches++;
      end else begin
        if (pending_status[0] != out_status_s) begin
          $display("%0t status mismatch: expected %0b, actual %0b",
                   $time, pending_status[0], out_status_s);
          mismatches++;
        end
        void'(pending_status.pop_front());
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [63:0] ones;
    ones = '1;
    sid_pool[0] = '0;
    sid_pool[1] = ones;
    sid_pool[2] = {$urandom, $urandom};
    sid_pool[3] = {$urandom, $urandom};

    stage_row(KIND_CHECK,   64'd7, 1'b0, OP_WRITE10,     8'h00, 1'b0, PR_NONE, 1, 1'b0);
    stage_row(KIND_RELEASE, 64'd7, 1'b0, 8'hFF,          8'hFF, 1'b1, 4'hF,    1, 1'b1);
    stage_row(KIND_RESERVE, ones,  1'b0, 8'h00,          8'h00, 1'b0, PR_NONE, 1, 1'b0);
    stage_row(KIND_RESERVE, '0,    1'b1, 8'hFF,          8'hFF, 1'b1, 4'hF,    1, 1'b1);
    stage_row(KIND_CHECK,   '0,    1'b0, OP_INQUIRY,     8'h00, 1'b0, PR_NONE, 0, 1'b0);
    stage_row(KIND_CHECK,   '0,    1'b0, OP_SERVICE_IN,  8'hF0, 1'b0, PR_NONE, 0, 1'b0);
    stage_row(KIND_CHECK,   '0,    1'b0, OP_SERVICE_IN,  8'h11, 1'b0, PR_NONE, 0, 1'b0);
    stage_row(KIND_CHECK,   '0,    1'b0, 8'hFF,          8'hFF, 1'b1, PR_NONE, 0, 1'b0);
    stage_row(KIND_CHECK,   ones,  1'b0, 8'hFF,          8'hFF, 1'b0, PR_NONE, 0, 1'b0);
    stage_row(KIND_RESERVE, ones,  1'b0, 8'h00,          8'h00, 1'b0, PR_NONE, 0, 1'b0);
    stage_row(KIND_RELEASE, '0,    1'b0, 8'h00,          8'h00, 1'b0, PR_NONE, 0, 1'b0);
    stage_row(KIND_RELEASE, '0,    1'b1, 8'h00,          8'h00, 1'b0, PR_NONE, 0, 1'b0);
    stage_row(KIND_PR_SET,  64'd5, 1'b0, 8'h00,          8'h00, 1'b0, PR_EA,   1, 1'b0);
    stage_row(KIND_CHECK,   64'd6, 1'b0, OP_READ10,      8'h00, 1'b1, PR_NONE, 0, 1'b0);
    stage_row(KIND_RELEASE, 64'd5, 1'b1, 8'h00,          8'h00, 1'b0, PR_NONE, 1, 1'b1);
    stage_row(KIND_PR_SET,  64'd5, 1'b0, 8'h00,          8'h00, 1'b0, PR_EA_RO, 1, 1'b0);
    stage_row(KIND_CHECK,   64'd6, 1'b0, OP_READ10,      8'h00, 1'b1, PR_NONE, 0, 1'b0);
    stage_row(KIND_CHECK,   64'd6, 1'b0, OP_READ10,      8'h00, 1'b0, PR_NONE, 0, 1'b0);
    stage_row(KIND_PR_SET,  64'd5, 1'b0, 8'h00,          8'h00, 1'b0, 4'hF,    1, 1'b0);
    stage_row(KIND_CHECK,   64'd6, 1'b0, OP_WRITE10,     8'h00, 1'b0, PR_NONE, 0, 1'b0);
    stage_row(KIND_CHECK,   64'd6, 1'b0, 8'hC0,          8'h00, 1'b0, PR_NONE, 0, 1'b0);
    stage_row(KIND_RESERVE, 64'd5, 1'b0, 8'h00,          8'h00, 1'b0, PR_NONE, 0, 1'b0);
    stage_row(KIND_CHECK,   64'd6, 1'b0, OP_START_STOP,  8'h00, 1'b0, PR_NONE, 0, 1'b0);
    stage_row(KIND_PR_SET,  64'd9, 1'b0, 8'h00,          8'h00, 1'b0, PR_NONE, 1, 1'b0);
    stage_row(KIND_CHECK,   64'd6, 1'b0, OP_WRITE10,     8'h00, 1'b0, PR_NONE, 0, 1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_idle = 34;
    recv_idle = 67;
    foreach (stim_rows[i]) begin
      offer_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].typed_status);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) begin
        send_idle = 67;
        recv_idle = 34;
      end else if (n == 2 * RANDOM_WORDS / 3) begin
        send_idle = 0;
        recv_idle = 0;
      end else if (n == 3 * RANDOM_WORDS / 4) begin
        hold_request = 1'b1;
      end
      offer_word(random_word(), 1'b0, 1'b0);
    end
    in_valid <= 1'b0;

    while (pending_status.size() != 0) begin
      @(posedge clk);
    end
    repeat (5) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/sra_pkg.sv
src/scsi_reservation_access_check.sv
test/tb_top.sv
